>>> src/cdt_pkg.sv
`timescale 1ns / 1ps

package cdt_pkg;

    // Default table geometry.
    localparam int DEF_ENTRIES   = 16;
    localparam int DEF_KEY_BITS  = 32;
    localparam int DEF_TIME_BITS = 32;

    // Widths of the word fields on the ports.
    localparam int KIND_W  = 3;
    localparam int KEY_W   = 32;
    localparam int NOW_W   = 32;
    localparam int LIMIT_W = 31;

    // Common width for widening keys, stamps and the age compare.
    localparam int WIDE_W = 64;

    typedef logic [KIND_W-1:0] t_kind;

    // Operation codes.
    localparam t_kind KIND_CHECK    = 3'd0;
    localparam t_kind KIND_CONTAINS = 3'd1;
    localparam t_kind KIND_REFRESH  = 3'd2;
    localparam t_kind KIND_INSERT   = 3'd3;
    localparam t_kind KIND_REMOVE   = 3'd4;
    localparam t_kind KIND_SWEEP    = 3'd5;

    // Result of comparing one table entry against the current word.
    typedef struct packed {
        logic key_eq;
        logic aged;
    } t_match;

endpackage

>>> src/cdt_mem.sv
`timescale 1ns / 1ps

module cdt_mem #(
    parameter int ENTRIES   = cdt_pkg::DEF_ENTRIES,
    parameter int KEY_BITS  = cdt_pkg::DEF_KEY_BITS,
    parameter int TIME_BITS = cdt_pkg::DEF_TIME_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_key_we,
    input  logic                       i_stamp_we,
    input  logic [$clog2(ENTRIES)-1:0] i_waddr,
    input  logic [KEY_BITS-1:0]        i_wkey,
    input  logic [TIME_BITS-1:0]       i_wstamp,
    input  logic [$clog2(ENTRIES)-1:0] i_raddr,
    output logic [KEY_BITS-1:0]        o_rkey,
    output logic [TIME_BITS-1:0]       o_rstamp
);
    import cdt_pkg::*;

    logic [KEY_BITS-1:0]  r_key_mem   [ENTRIES];
    logic [TIME_BITS-1:0] r_stamp_mem [ENTRIES];

    // One write port per array, one shared read address with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_key_we) begin
            r_key_mem[i_waddr] <= i_wkey;
        end
        if (i_stamp_we) begin
            r_stamp_mem[i_waddr] <= i_wstamp;
        end
        o_rkey   <= r_key_mem[i_raddr];
        o_rstamp <= r_stamp_mem[i_raddr];
    end

endmodule

>>> src/cdt_match.sv
`timescale 1ns / 1ps

module cdt_match #(
    parameter int KEY_BITS  = cdt_pkg::DEF_KEY_BITS,
    parameter int TIME_BITS = cdt_pkg::DEF_TIME_BITS
) (
    input  logic [KEY_BITS-1:0]         i_entry_key,
    input  logic [TIME_BITS-1:0]        i_entry_stamp,
    input  logic [KEY_BITS-1:0]         i_key,
    input  logic [TIME_BITS-1:0]        i_now,
    input  logic [cdt_pkg::LIMIT_W-1:0] i_limit,
    output cdt_pkg::t_match             o_match
);
    import cdt_pkg::*;

    logic [TIME_BITS-1:0] w_elapsed;
    logic [WIDE_W-1:0]    w_elapsed_wide;
    logic [WIDE_W-1:0]    w_limit_wide;

    // Elapsed time wraps at the stamp width; compare it unsigned to the limit.
    assign w_elapsed      = i_now - i_entry_stamp;
    assign w_elapsed_wide = WIDE_W'(w_elapsed);
    assign w_limit_wide   = WIDE_W'(i_limit);

    assign o_match.key_eq = (i_entry_key == i_key);
    assign o_match.aged   = (w_elapsed_wide > w_limit_wide);

endmodule

>>> src/cooldown_timestamp_table.sv
// Each word is handled by a single-port scan of every entry of the key/stamp memory
// through the shared compare unit; o_stall stays high and no new word is accepted
// until the sequencer returns to idle after posting the result.
// A result waiting on i_stall does not block acceptance of the next word.
// Reset (synchronous, active low) clears all valid bits, the sequencer and
// the output valid flag; key and stamp memories are not cleared.
`timescale 1ns / 1ps

module cooldown_timestamp_table #(
    parameter int ENTRIES   = cdt_pkg::DEF_ENTRIES,
    parameter int KEY_BITS  = cdt_pkg::DEF_KEY_BITS,
    parameter int TIME_BITS = cdt_pkg::DEF_TIME_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  cdt_pkg::t_kind              i_kind,
    input  logic [cdt_pkg::KEY_W-1:0]   i_key,
    input  logic [cdt_pkg::NOW_W-1:0]   i_now,
    input  logic [cdt_pkg::LIMIT_W-1:0] i_age_limit,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_ok,
    output logic                        o_table_full
);
    import cdt_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    // Control state.
    logic [1:0]         r_state, n_state;
    logic [IDX_W-1:0]   r_addr, n_addr;
    logic               r_issuing, n_issuing;
    logic               r_pend, n_pend;
    logic [IDX_W-1:0]   r_eval_idx, n_eval_idx;
    logic [ENTRIES-1:0] r_valid, n_valid;
    logic               r_out_valid, n_out_valid;

    // Scan results.
    logic               r_hit_found, n_hit_found;
    logic [IDX_W-1:0]   r_hit_idx, n_hit_idx;
    logic               r_hit_aged, n_hit_aged;
    logic               r_free_found, n_free_found;
    logic [IDX_W-1:0]   r_free_idx, n_free_idx;

    // Latched word and result payload.
    t_kind              r_kind;
    logic [KEY_BITS-1:0]  r_key;
    logic [TIME_BITS-1:0] r_now;
    logic [LIMIT_W-1:0]   r_limit;
    logic               r_ok, n_ok;
    logic               r_full, n_full;

    logic                 w_accept;
    logic [WIDE_W-1:0]    w_key_wide;
    logic [WIDE_W-1:0]    w_now_wide;
    logic                 w_key_we;
    logic                 w_stamp_we;
    logic [IDX_W-1:0]     w_waddr;
    logic [KEY_BITS-1:0]  w_rkey;
    logic [TIME_BITS-1:0] w_rstamp;
    logic                 w_entry_valid;
    t_match               w_match;

    assign o_stall      = (r_state != ST_IDLE);
    assign w_accept     = i_valid && !o_stall;
    assign o_valid      = r_out_valid;
    assign o_ok         = r_ok;
    assign o_table_full = r_full;

    // Key and time fields are taken at the table's own widths.
    assign w_key_wide = WIDE_W'(i_key);
    assign w_now_wide = WIDE_W'(i_now);

    cdt_mem #(
        .ENTRIES   (ENTRIES),
        .KEY_BITS  (KEY_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_mem (
        .i_clk      (i_clk),
        .i_key_we   (w_key_we),
        .i_stamp_we (w_stamp_we),
        .i_waddr    (w_waddr),
        .i_wkey     (r_key),
        .i_wstamp   (r_now),
        .i_raddr    (r_addr),
        .o_rkey     (w_rkey),
        .o_rstamp   (w_rstamp)
    );

    cdt_match #(
        .KEY_BITS  (KEY_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_match (
        .i_entry_key   (w_rkey),
        .i_entry_stamp (w_rstamp),
        .i_key         (r_key),
        .i_now         (r_now),
        .i_limit       (r_limit),
        .o_match       (w_match)
    );

    assign w_entry_valid = r_valid[r_eval_idx];

    // Sequencer: scan every entry once, then apply the operation and post the result.
    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_issuing    = r_issuing;
        n_pend       = 1'b0;
        n_eval_idx   = r_eval_idx;
        n_valid      = r_valid;
        n_hit_found  = r_hit_found;
        n_hit_idx    = r_hit_idx;
        n_hit_aged   = r_hit_aged;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_out_valid  = r_out_valid && i_stall;
        n_ok         = r_ok;
        n_full       = r_full;
        w_key_we     = 1'b0;
        w_stamp_we   = 1'b0;
        w_waddr      = r_hit_idx;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state      = ST_SCAN;
                    n_addr       = '0;
                    n_issuing    = 1'b1;
                    n_hit_found  = 1'b0;
                    n_free_found = 1'b0;
                end
            end
            ST_SCAN: begin
                // Issue reads one entry per cycle.
                if (r_issuing) begin
                    n_pend     = 1'b1;
                    n_eval_idx = r_addr;
                    if (r_addr == LAST_IDX) begin
                        n_issuing = 1'b0;
                    end else begin
                        n_addr = r_addr + 1'b1;
                    end
                end
                // Evaluate the entry read in the previous cycle.
                if (r_pend) begin
                    if (w_entry_valid && w_match.key_eq && !r_hit_found) begin
                        n_hit_found = 1'b1;
                        n_hit_idx   = r_eval_idx;
                        n_hit_aged  = w_match.aged;
                    end
                    if (!w_entry_valid && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_eval_idx;
                    end
                    if (r_kind == KIND_SWEEP && w_entry_valid && w_match.aged) begin
                        n_valid[r_eval_idx] = 1'b0;
                    end
                    if (r_eval_idx == LAST_IDX) begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_ok        = 1'b0;
                    n_full      = 1'b0;
                    n_state     = ST_IDLE;
                    case (r_kind)
                        KIND_CHECK: begin
                            n_ok = r_hit_found && r_hit_aged;
                        end
                        KIND_CONTAINS: begin
                            n_ok = r_hit_found;
                        end
                        KIND_REFRESH: begin
                            if (r_hit_found) begin
                                w_stamp_we = 1'b1;
                                n_ok       = 1'b1;
                            end
                        end
                        KIND_INSERT: begin
                            if (!r_hit_found) begin
                                if (r_free_found) begin
                                    w_waddr             = r_free_idx;
                                    w_key_we            = 1'b1;
                                    w_stamp_we          = 1'b1;
                                    n_valid[r_free_idx] = 1'b1;
                                    n_ok                = 1'b1;
                                end else begin
                                    n_full = 1'b1;
                                end
                            end
                        end
                        KIND_REMOVE: begin
                            if (r_hit_found) begin
                                n_valid[r_hit_idx] = 1'b0;
                                n_ok               = 1'b1;
                            end
                        end
                        KIND_SWEEP: begin
                            n_ok = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_addr      <= '0;
            r_issuing   <= 1'b0;
            r_pend      <= 1'b0;
            r_eval_idx  <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_issuing   <= n_issuing;
            r_pend      <= n_pend;
            r_eval_idx  <= n_eval_idx;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Scan results, latched word and result payload.
    always_ff @(posedge i_clk) begin
        r_hit_found  <= n_hit_found;
        r_hit_idx    <= n_hit_idx;
        r_hit_aged   <= n_hit_aged;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_ok         <= n_ok;
        r_full       <= n_full;
        if (w_accept) begin
            r_kind  <= i_kind;
            r_key   <= w_key_wide[KEY_BITS-1:0];
            r_now   <= w_now_wide[TIME_BITS-1:0];
            r_limit <= i_age_limit;
        end
    end

`ifndef NO_ASSERTIONS
    // A failed insert never reports success at the same time.
    a_ok_full_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_ok && o_table_full))
        else $error("ok and table_full both set");

    // The last evaluated entry always hands over to the finish step.
    a_scan_to_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && r_pend && r_eval_idx == LAST_IDX) |=> (r_state == ST_FINISH))
        else $error("scan did not end in finish");

    // No read stays in flight once the sequencer is idle.
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend)
        else $error("pending read while idle");

    // A successful insert leaves its slot valid.
    a_insert_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH && (!r_out_valid || !i_stall) && r_kind == KIND_INSERT
         && !r_hit_found && r_free_found) |=> r_valid[$past(r_free_idx)])
        else $error("inserted slot not valid");
`endif

endmodule
